// ===== sv/tiis_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tiis_pkg
// shared constants, register codes and helpers for the three-impulse shaper
// ----------------------------------------------------------------------------
package tiis_pkg;

    // defaults for the top-level parameters
    localparam int unsigned HISTORY_DEPTH_DEF = 256;
    localparam int unsigned SAMPLE_WIDTH_DEF  = 16;

    // gain format: Q2.15, 32768 is 1.0
    localparam int unsigned AMP_W    = 17;
    localparam int unsigned AMP_FRAC = 15;
    localparam int unsigned DELAY_W  = 8;

    // apb port
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 5;

    // reset shaper: 0.25 / 0.5 / 0.25 at delays 0, 2, 5
    localparam logic signed [AMP_W-1:0] AMP_FIRST_RST  = 17'sd8192;
    localparam logic signed [AMP_W-1:0] AMP_SECOND_RST = 17'sd16384;
    localparam logic signed [AMP_W-1:0] AMP_THIRD_RST  = 17'sd8192;
    localparam logic [DELAY_W-1:0]      DELAY_SECOND_RST = 8'd2;
    localparam logic [DELAY_W-1:0]      DELAY_THIRD_RST  = 8'd5;

    typedef enum logic [2:0] {
        REG_AMP_FIRST    = 3'd0,
        REG_AMP_SECOND   = 3'd1,
        REG_AMP_THIRD    = 3'd2,
        REG_DELAY_SECOND = 3'd3,
        REG_DELAY_THIRD  = 3'd4
    } reg_idx_t;

    // delay modulo ring depth, restoring remainder over the delay bits
    function automatic logic [DELAY_W-1:0] delay_mod(input logic [DELAY_W-1:0] d,
                                                     input int unsigned depth);
        int unsigned r;
        r = int'(d);
        for (int k = DELAY_W - 1; k >= 0; k--) begin
            if (r >= (depth << k)) begin
                r = r - (depth << k);
            end
        end
        return DELAY_W'(r);
    endfunction

endpackage
`default_nettype wire

// ===== sv/three_impulse_input_shaper.sv =====
`timescale 1ns / 1ps
`default_nettype none
// an input transaction passes the stage 1, product and output registers in turn
// throughput: one transaction per cycle unless stalled, set by the two-read one-write history ram
// a stalled output holds its own register and each full stage behind it; empty stages keep filling
// reset: gains and delays return to the 0.25 / 0.5 / 0.25 shaper at 0, 2, 5
// reset: history reads as zero through a fill count, no clearing pass needed
// ----------------------------------------------------------------------------
// three_impulse_input_shaper
// sparse three-tap fir over a ring of past command samples, q2.15 gains,
// floor shift by 15 and saturation to the sample width
// ----------------------------------------------------------------------------
module three_impulse_input_shaper
    import tiis_pkg::*;
#(
    parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int unsigned SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    // apb configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [APB_ADDR_W-1:0]          paddr,
    input  wire logic [APB_DATA_W-1:0]          pwdata,
    output logic      [APB_DATA_W-1:0]          prdata,
    output logic                                pready,

    // input channel
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] command_sample,

    // output channel
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]      shaped_sample,
    output logic                                saturated
);

    localparam int unsigned IDX_W  = $clog2(HISTORY_DEPTH);
    localparam int unsigned FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int unsigned PROD_W = AMP_W + SAMPLE_WIDTH;
    localparam int unsigned SUM_W  = PROD_W + 2;

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(HISTORY_DEPTH);
    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(HISTORY_DEPTH - 1);
    localparam logic [IDX_W:0]    DEPTH_X   = (IDX_W + 1)'(HISTORY_DEPTH);

    localparam logic signed [SUM_W-1:0] SAT_MAX =
        {{(SUM_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_MIN =
        {{(SUM_W - SAMPLE_WIDTH + 1){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic signed [AMP_W-1:0] amp_first_reg;
    logic signed [AMP_W-1:0] amp_second_reg;
    logic signed [AMP_W-1:0] amp_third_reg;
    logic [DELAY_W-1:0]      delay_second_reg;
    logic [DELAY_W-1:0]      delay_third_reg;
    // delays already reduced modulo the ring depth
    logic [IDX_W-1:0]        dmod_second_reg;
    logic [IDX_W-1:0]        dmod_third_reg;

    logic     cfg_wr;
    reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_first_reg    <= AMP_FIRST_RST;
            amp_second_reg   <= AMP_SECOND_RST;
            amp_third_reg    <= AMP_THIRD_RST;
            delay_second_reg <= DELAY_SECOND_RST;
            delay_third_reg  <= DELAY_THIRD_RST;
            dmod_second_reg  <= IDX_W'(delay_mod(DELAY_SECOND_RST, HISTORY_DEPTH));
            dmod_third_reg   <= IDX_W'(delay_mod(DELAY_THIRD_RST, HISTORY_DEPTH));
        end
        else if (cfg_wr)
        begin
            // addresses past the register list are ignored
            unique case (cfg_idx)
                REG_AMP_FIRST:    amp_first_reg  <= pwdata[AMP_W-1:0];
                REG_AMP_SECOND:   amp_second_reg <= pwdata[AMP_W-1:0];
                REG_AMP_THIRD:    amp_third_reg  <= pwdata[AMP_W-1:0];
                REG_DELAY_SECOND:
                begin
                    delay_second_reg <= pwdata[DELAY_W-1:0];
                    dmod_second_reg  <= IDX_W'(delay_mod(pwdata[DELAY_W-1:0],
                                                         HISTORY_DEPTH));
                end
                REG_DELAY_THIRD:
                begin
                    delay_third_reg <= pwdata[DELAY_W-1:0];
                    dmod_third_reg  <= IDX_W'(delay_mod(pwdata[DELAY_W-1:0],
                                                        HISTORY_DEPTH));
                end
                default:
                begin
                end
            endcase
        end
    end

    // read back: gains sign-extended, delays zero-extended
    always_comb
    begin
        unique case (cfg_idx)
            REG_AMP_FIRST:    prdata = APB_DATA_W'(amp_first_reg);
            REG_AMP_SECOND:   prdata = APB_DATA_W'(amp_second_reg);
            REG_AMP_THIRD:    prdata = APB_DATA_W'(amp_third_reg);
            REG_DELAY_SECOND: prdata = APB_DATA_W'(delay_second_reg);
            REG_DELAY_THIRD:  prdata = APB_DATA_W'(delay_third_reg);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline flow control: each stage moves when the one after it frees
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic en1;
    logic en2;
    logic en3;
    logic accept;

    assign en3      = !out_valid_reg || out_ready;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;
    assign accept   = in_valid && en1;

    // ------------------------------------------------------------------
    // stage 0: ring addressing and history write
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]  wr_ptr_reg;
    logic [IDX_W-1:0]  wr_ptr_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [IDX_W:0]    diff2;
    logic [IDX_W:0]    diff3;
    logic [IDX_W-1:0]  rd_idx2;
    logic [IDX_W-1:0]  rd_idx3;
    logic              hit2;
    logic              hit3;

    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == IDX_LAST) ? '0 : wr_ptr_reg + 1'b1;
        fill_next   = (fill_reg == FILL_FULL) ? fill_reg : fill_reg + 1'b1;

        // write pointer minus delay, wrapped into the ring
        diff2   = {1'b0, wr_ptr_reg} - {1'b0, dmod_second_reg};
        diff3   = {1'b0, wr_ptr_reg} - {1'b0, dmod_third_reg};
        rd_idx2 = diff2[IDX_W] ? IDX_W'(diff2 + DEPTH_X) : diff2[IDX_W-1:0];
        rd_idx3 = diff3[IDX_W] ? IDX_W'(diff3 + DEPTH_X) : diff3[IDX_W-1:0];

        // entries are written in ring order, so below the fill count means written
        hit2 = FILL_W'(rd_idx2) < fill_reg;
        hit3 = FILL_W'(rd_idx3) < fill_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else if (accept)
        begin
            wr_ptr_reg <= wr_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // history ram: one write port, two registered read ports
    logic signed [SAMPLE_WIDTH-1:0] hist_mem [HISTORY_DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] rd2_reg;
    logic signed [SAMPLE_WIDTH-1:0] rd3_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hist_mem[wr_ptr_reg] <= command_sample;
        end
        if (en1)
        begin
            rd2_reg <= hist_mem[rd_idx2];
            rd3_reg <= hist_mem[rd_idx3];
        end
    end

    // ------------------------------------------------------------------
    // stage 1: tap select with zero-delay forwarding, then multiply
    // ------------------------------------------------------------------
    logic signed [SAMPLE_WIDTH-1:0] x1_reg;
    logic                           hit2_reg;
    logic                           hit3_reg;
    logic                           fwd2_reg;
    logic                           fwd3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en1)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            x1_reg   <= command_sample;
            hit2_reg <= hit2;
            hit3_reg <= hit3;
            // zero delay reads the sample being written in the same transaction
            fwd2_reg <= (dmod_second_reg == '0);
            fwd3_reg <= (dmod_third_reg == '0);
        end
    end

    logic signed [SAMPLE_WIDTH-1:0] tap2;
    logic signed [SAMPLE_WIDTH-1:0] tap3;
    logic signed [PROD_W-1:0]       p1_next;
    logic signed [PROD_W-1:0]       p2_next;
    logic signed [PROD_W-1:0]       p3_next;

    always_comb
    begin
        if (fwd2_reg)
            tap2 = x1_reg;
        else if (hit2_reg)
            tap2 = rd2_reg;
        else
            tap2 = '0;

        if (fwd3_reg)
            tap3 = x1_reg;
        else if (hit3_reg)
            tap3 = rd3_reg;
        else
            tap3 = '0;

        p1_next = PROD_W'(amp_first_reg) * PROD_W'(x1_reg);
        p2_next = PROD_W'(amp_second_reg) * PROD_W'(tap2);
        p3_next = PROD_W'(amp_third_reg) * PROD_W'(tap3);
    end

    // ------------------------------------------------------------------
    // stage 2: product registers, then sum, floor shift and clip
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] p1_reg;
    logic signed [PROD_W-1:0] p2_reg;
    logic signed [PROD_W-1:0] p3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en2)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            p3_reg <= p3_next;
        end
    end

    logic signed [SUM_W-1:0]        sum;
    logic signed [SUM_W-1:0]        shifted;
    logic signed [SAMPLE_WIDTH-1:0] shaped_next;
    logic                           sat_next;

    always_comb
    begin
        sum     = SUM_W'(p1_reg) + SUM_W'(p2_reg) + SUM_W'(p3_reg);
        // arithmetic shift rounds toward minus infinity
        shifted = sum >>> AMP_FRAC;
        priority if (shifted > SAT_MAX)
        begin
            shaped_next = SAT_MAX[SAMPLE_WIDTH-1:0];
            sat_next    = 1'b1;
        end
        else if (shifted < SAT_MIN)
        begin
            shaped_next = SAT_MIN[SAMPLE_WIDTH-1:0];
            sat_next    = 1'b1;
        end
        else
        begin
            shaped_next = shifted[SAMPLE_WIDTH-1:0];
            sat_next    = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic signed [SAMPLE_WIDTH-1:0] shaped_reg;
    logic                           sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en3)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            shaped_reg <= shaped_next;
            sat_reg    <= sat_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign shaped_sample = shaped_reg;
    assign saturated     = sat_reg;

endmodule
`default_nettype wire

// ===== sv/tiis_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tiis_checker
// port-level checks for the three-impulse shaper, bound to the top level
// ----------------------------------------------------------------------------
module tiis_checker
    import tiis_pkg::*;
#(
    parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_ready,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire logic signed [SAMPLE_WIDTH-1:0] shaped_sample,
    input wire logic                           saturated
);

    localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

    // a pending result stays until its transaction completes
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transaction");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(shaped_sample) && $stable(saturated))
        else $error("stalled result changed");

    // a clipped result sits at one of the range limits
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> shaped_sample == OUT_MAX || shaped_sample == OUT_MIN)
        else $error("saturated flag on unclipped value");

    // a free or draining output never blocks the input side
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("input stalled with output free");

endmodule

bind three_impulse_input_shaper tiis_checker #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_tiis_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .shaped_sample(shaped_sample),
    .saturated    (saturated)
);
`default_nettype wire

// ===== test/tb_three_impulse_input_shaper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_impulse_input_shaper
// self-checking bench for the three-impulse shaper: command samples go in as
// random bursts and every shaped sample is compared with an in-bench shaper
// model, across gain and delay settings that are written and read back over apb
// ----------------------------------------------------------------------------
module tb_three_impulse_input_shaper;
    import tiis_pkg::*;

    localparam int unsigned SAMPLE_W    = SAMPLE_WIDTH_DEF;
    localparam int unsigned HIST_DEPTH  = HISTORY_DEPTH_DEF;
    localparam int unsigned PTR_W       = $clog2(HISTORY_DEPTH_DEF);
    localparam int          LATENCY     = 3;
    localparam int          REG_COUNT   = 5;
    localparam int          ADDR_SLOTS  = (1 << APB_ADDR_W) / 4;
    localparam int          CYCLE_LIMIT = 500000;
    localparam int          RANDOM_TARGET = 1000;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [AMP_W-1:0]    GAIN_MAX   = {1'b0, {(AMP_W-1){1'b1}}};
    localparam logic signed [AMP_W-1:0]    GAIN_MIN   = {1'b1, {(AMP_W-1){1'b0}}};
    localparam logic [DELAY_W-1:0]         DELAY_MAX  = '1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] shaped;
        logic                       clipped;
    } shaped_result_t;

    typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_LONG} stall_mode_t;
    typedef enum {CMD_FULL, CMD_SMALL, CMD_STEPS, CMD_EXTREME} command_style_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    // apb port
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // command and shaped channels
    logic                       in_valid       = 1'b0;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] command_sample = '0;
    logic                       out_valid;
    logic                       out_ready      = 1'b0;
    logic signed [SAMPLE_W-1:0] shaped_sample;
    logic                       saturated;

    three_impulse_input_shaper dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command_sample (command_sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .shaped_sample  (shaped_sample),
        .saturated      (saturated)
    );

    // commands waiting to be sent, and shaped samples still owed by the dut
    logic signed [SAMPLE_W-1:0] command_queue[$];
    shaped_result_t             shaped_due[$];

    // shaper copy kept by the bench, same reset values as the block
    logic signed [AMP_W-1:0]    gain_first   = AMP_FIRST_RST;
    logic signed [AMP_W-1:0]    gain_second  = AMP_SECOND_RST;
    logic signed [AMP_W-1:0]    gain_third   = AMP_THIRD_RST;
    logic [DELAY_W-1:0]         delay_second = DELAY_SECOND_RST;
    logic [DELAY_W-1:0]         delay_third  = DELAY_THIRD_RST;
    logic signed [SAMPLE_W-1:0] cmd_history [HIST_DEPTH];
    logic [PTR_W-1:0]           hist_ptr     = '0;

    int errors           = 0;
    int commands_sent    = 0;
    int results_checked  = 0;
    int clipped_seen     = 0;
    int settings_written = 0;
    int cycle_count      = 0;

    // one shaper step: store the sample, then sum the three taps
    function automatic shaped_result_t shape_command(input logic signed [SAMPLE_W-1:0] x);
        logic [PTR_W-1:0] tap_second;
        logic [PTR_W-1:0] tap_third;
        longint           acc;
        shaped_result_t   r;
        cmd_history[hist_ptr] = x;
        tap_second = hist_ptr - delay_second;
        tap_third  = hist_ptr - delay_third;
        acc = longint'(gain_first) * longint'(x)
            + longint'(gain_second) * longint'(cmd_history[tap_second])
            + longint'(gain_third) * longint'(cmd_history[tap_third]);
        // arithmetic shift floors toward minus infinity
        acc = acc >>> AMP_FRAC;
        r.clipped = 1'b1;
        if (acc > longint'(SAMPLE_MAX))
            r.shaped = SAMPLE_MAX;
        else if (acc < longint'(SAMPLE_MIN))
            r.shaped = SAMPLE_MIN;
        else
        begin
            r.shaped  = SAMPLE_W'(acc);
            r.clipped = 1'b0;
        end
        hist_ptr = hist_ptr + 1'b1;
        return r;
    endfunction

    // register write as the block sees it; unknown indexes change nothing
    function automatic void apply_register(input int idx, input logic [APB_DATA_W-1:0] v);
        if (idx < REG_COUNT)
        begin
            case (reg_idx_t'(idx))
                REG_AMP_FIRST:    gain_first   = v[AMP_W-1:0];
                REG_AMP_SECOND:   gain_second  = v[AMP_W-1:0];
                REG_AMP_THIRD:    gain_third   = v[AMP_W-1:0];
                REG_DELAY_SECOND: delay_second = v[DELAY_W-1:0];
                REG_DELAY_THIRD:  delay_third  = v[DELAY_W-1:0];
                default: ;
            endcase
        end
    endfunction

    function automatic logic [APB_DATA_W-1:0] register_image(input reg_idx_t idx);
        case (idx)
            REG_AMP_FIRST:    return APB_DATA_W'(unsigned'(gain_first));
            REG_AMP_SECOND:   return APB_DATA_W'(unsigned'(gain_second));
            REG_AMP_THIRD:    return APB_DATA_W'(unsigned'(gain_third));
            REG_DELAY_SECOND: return APB_DATA_W'(delay_second);
            default:          return APB_DATA_W'(delay_third);
        endcase
    endfunction

    function automatic logic [APB_DATA_W-1:0] field_mask(input reg_idx_t idx);
        if (idx == REG_DELAY_SECOND || idx == REG_DELAY_THIRD)
            return (APB_DATA_W'(1) << DELAY_W) - 1;
        return (APB_DATA_W'(1) << AMP_W) - 1;
    endfunction

    function automatic logic signed [AMP_W-1:0] pick_gain();
        case ($urandom_range(0, 6))
            0:       return GAIN_MAX;
            1:       return GAIN_MIN;
            2:       return '0;
            3, 4:    return AMP_W'($urandom_range(0, 16384));
            default: return AMP_W'($urandom);
        endcase
    endfunction

    function automatic logic [DELAY_W-1:0] pick_delay();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return DELAY_MAX;
            2, 3:    return DELAY_W'($urandom_range(1, 20));
            default: return DELAY_W'($urandom);
        endcase
    endfunction

    // one apb transfer, setup then access; the write lands at the access edge
    task automatic apb_transfer(input logic write, input int idx,
                                input logic [APB_DATA_W-1:0] wdata,
                                output logic [APB_DATA_W-1:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= APB_ADDR_W'(4 * idx);
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (write)
            apply_register(idx, wdata);
    endtask

    // program a full shaper setting with noise above each field, poke an
    // unmapped slot, then read every register back
    task automatic write_shaper(input logic signed [AMP_W-1:0] g1,
                                input logic signed [AMP_W-1:0] g2,
                                input logic signed [AMP_W-1:0] g3,
                                input logic [DELAY_W-1:0] d2,
                                input logic [DELAY_W-1:0] d3);
        logic [APB_DATA_W-1:0] fields [REG_COUNT];
        logic [APB_DATA_W-1:0] rd;
        logic [APB_DATA_W-1:0] m;
        fields[REG_AMP_FIRST]    = APB_DATA_W'(unsigned'(g1));
        fields[REG_AMP_SECOND]   = APB_DATA_W'(unsigned'(g2));
        fields[REG_AMP_THIRD]    = APB_DATA_W'(unsigned'(g3));
        fields[REG_DELAY_SECOND] = APB_DATA_W'(d2);
        fields[REG_DELAY_THIRD]  = APB_DATA_W'(d3);
        for (int i = 0; i < REG_COUNT; i++)
        begin
            m = field_mask(reg_idx_t'(i));
            apb_transfer(1'b1, i, (APB_DATA_W'($urandom) & ~m) | (fields[i] & m), rd);
        end
        apb_transfer(1'b1, $urandom_range(REG_COUNT, ADDR_SLOTS - 1), $urandom, rd);
        for (int i = 0; i < REG_COUNT; i++)
        begin
            apb_transfer(1'b0, i, '0, rd);
            m = field_mask(reg_idx_t'(i));
            if (((rd ^ register_image(reg_idx_t'(i))) & m) != '0)
            begin
                $error("register %0d readback mismatch: expected %0h, actual %0h",
                       i, register_image(reg_idx_t'(i)) & m, rd & m);
                errors++;
            end
        end
        settings_written++;
        @(negedge clk);
    endtask

    task automatic queue_commands(input int count, input command_style_t style);
        logic signed [SAMPLE_W-1:0] level;
        int                         run_left;
        level    = '0;
        run_left = 0;
        for (int k = 0; k < count; k++)
        begin
            case (style)
                CMD_FULL:  level = SAMPLE_W'($urandom);
                CMD_SMALL: level = SAMPLE_W'($urandom_range(0, 2000)) - SAMPLE_W'(1000);
                CMD_STEPS:
                begin
                    // held velocity levels, the usual shape of a motion command
                    if (run_left == 0)
                    begin
                        level    = ($urandom_range(0, 3) == 0) ? '0 : SAMPLE_W'($urandom);
                        run_left = $urandom_range(5, 60);
                    end
                    run_left--;
                end
                default:
                begin
                    case ($urandom_range(0, 3))
                        0:       level = SAMPLE_MAX;
                        1:       level = SAMPLE_MIN;
                        2:       level = '0;
                        default: level = SAMPLE_W'($urandom);
                    endcase
                end
            endcase
            command_queue.push_back(level);
        end
    endtask

    // sender stops on its own once the queue is empty; wait for the dut to drain
    task automatic wait_idle();
        while (command_queue.size() != 0 || in_valid || shaped_due.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 2) @(negedge clk);
    endtask

    // driver: bursts of transactions with random gaps in between
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid       <= 1'b0;
            command_sample <= '0;
            burst_left     <= 0;
            gap_left       <= 0;
        end
        else
        begin
            // accepted transaction: the model steps exactly when the dut does
            if (in_valid && in_ready)
            begin
                shaped_due.push_back(shape_command(command_sample));
                commands_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (command_queue.size() != 0)
                begin
                    in_valid       <= 1'b1;
                    command_sample <= command_queue.pop_front();
                    if (burst_left <= 1)
                    begin
                        // a long burst now and then leaves stretches with no idling
                        burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                                   : $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall behavior switches between modes, each chosen at random
    stall_mode_t stall_mode = STALL_NONE;
    int          mode_left  = 0;
    int          stall_left = 0;
    int          stall_tick = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_mode <= STALL_NONE;
            mode_left  <= 0;
            stall_left <= 0;
            stall_tick <= 0;
        end
        else
        begin
            stall_tick <= stall_tick + 1;
            if (mode_left == 0)
            begin
                stall_mode <= stall_mode_t'($urandom_range(0, 3));
                mode_left  <= $urandom_range(50, 300);
            end
            else
                mode_left <= mode_left - 1;
            case (stall_mode)
                STALL_NONE:     out_ready <= 1'b1;
                STALL_RANDOM:   out_ready <= 1'($urandom_range(0, 1));
                STALL_PERIODIC: out_ready <= (stall_tick % 5) > 1;
                default:
                begin
                    if (stall_left != 0)
                    begin
                        out_ready  <= 1'b0;
                        stall_left <= stall_left - 1;
                    end
                    else if ($urandom_range(0, 7) == 0)
                    begin
                        out_ready  <= 1'b0;
                        stall_left <= $urandom_range(3, 20);
                    end
                    else
                        out_ready <= 1'b1;
                end
            endcase
        end
    end

    // monitor: each shaped transaction against the oldest owed result
    always @(posedge clk)
    begin : shaped_check
        shaped_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_checked++;
            if (saturated === 1'b1)
                clipped_seen++;
            if (shaped_due.size() == 0)
            begin
                $error("shaped transaction with none owed: shaped_sample %0d saturated %0b",
                       shaped_sample, saturated);
                errors++;
            end
            else
            begin
                want = shaped_due.pop_front();
                if (shaped_sample !== want.shaped)
                begin
                    $error("shaped_sample mismatch: expected %0d, actual %0d",
                           want.shaped, shaped_sample);
                    errors++;
                end
                if (saturated !== want.clipped)
                begin
                    $error("saturated mismatch: expected %0b, actual %0b",
                           want.clipped, saturated);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // stimulus sequence
    initial
    begin : stimulus
        int                 queued;
        int                 n;
        logic [DELAY_W-1:0] d2;
        queued = 0;
        for (int i = 0; i < HIST_DEPTH; i++)
            cmd_history[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset shaper, sample extremes and alternating bit patterns
        command_queue.push_back(SAMPLE_MAX);
        command_queue.push_back(SAMPLE_MAX);
        command_queue.push_back(SAMPLE_MAX);
        command_queue.push_back(SAMPLE_MIN);
        command_queue.push_back(SAMPLE_MIN);
        command_queue.push_back('0);
        command_queue.push_back(SAMPLE_W'(1));
        command_queue.push_back('1);
        command_queue.push_back(16'sh5555);
        command_queue.push_back(16'shAAAA);
        wait_idle();

        // largest gains, both taps undelayed: clips both ways
        write_shaper(GAIN_MAX, GAIN_MAX, GAIN_MAX, '0, '0);
        command_queue.push_back(SAMPLE_MAX);
        command_queue.push_back(SAMPLE_MIN);
        command_queue.push_back(SAMPLE_W'(1));
        command_queue.push_back('1);
        wait_idle();

        // most negative gains, both taps at the deepest delay
        write_shaper(GAIN_MIN, GAIN_MIN, GAIN_MIN, DELAY_MAX, DELAY_MAX);
        command_queue.push_back(SAMPLE_MAX);
        command_queue.push_back(SAMPLE_MIN);
        command_queue.push_back(SAMPLE_W'(100));
        command_queue.push_back(-SAMPLE_W'(100));
        wait_idle();

        // unity second tap, a one-lsb third tap, neighbors in the ring
        write_shaper('0, AMP_W'(32768), AMP_W'(1), DELAY_W'(1), DELAY_W'(254));
        command_queue.push_back(SAMPLE_MAX);
        command_queue.push_back(-SAMPLE_W'(12345));
        command_queue.push_back(SAMPLE_MIN);
        wait_idle();

        // random settings, each followed by a stretch of commands and a full drain
        while (queued < RANDOM_TARGET)
        begin
            d2 = pick_delay();
            write_shaper(pick_gain(), pick_gain(), pick_gain(), d2,
                         ($urandom_range(0, 3) == 0) ? d2 : pick_delay());
            n = $urandom_range(60, 180);
            queue_commands(n, command_style_t'($urandom_range(0, 3)));
            queued += n;
            wait_idle();
        end

        // back to the reset shaper for a last stretch of motion commands
        write_shaper(AMP_FIRST_RST, AMP_SECOND_RST, AMP_THIRD_RST,
                     DELAY_SECOND_RST, DELAY_THIRD_RST);
        queue_commands(100, CMD_STEPS);
        wait_idle();
        repeat (4 * LATENCY) @(negedge clk);

        if (shaped_due.size() != 0)
        begin
            $error("%0d shaped results never arrived", shaped_due.size());
            errors++;
        end
        $display("shaped %0d command samples under %0d register settings",
                 commands_sent, settings_written);
        $display("checked %0d results, %0d of them clipped, %0d errors",
                 results_checked, clipped_seen, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
